// ===== hw/rtl/lrc_pkg.sv =====
// ----------------------------------------------------------------------------
// lrc_pkg
// Shared types and constants of the LRU result cache.
// ----------------------------------------------------------------------------
package lrc_pkg;
    localparam int ENTRIES          = 64;
    localparam int IDX_W            = $clog2(ENTRIES);
    localparam int CNT_W            = $clog2(ENTRIES + 1);
    localparam int PAYLOAD_BITS     = 64;
    localparam int BASE_BYTES       = 64;
    localparam int DESCRIPTOR_BYTES = 32;
    localparam logic [15:0] ALL_COLUMNS = 16'hFFFF;
    localparam logic [31:0] MAX_BYTES_RESET = 32'd65536;

    localparam logic [2:0] MODE_LOOKUP = 3'd0;
    localparam logic [2:0] MODE_PROBE  = 3'd1;
    localparam logic [2:0] MODE_PUT    = 3'd2;
    localparam logic [2:0] MODE_INVAL  = 3'd3;
    localparam logic [2:0] MODE_CLEAR  = 3'd4;

    typedef struct packed {
        logic       load;     // capture word, run key match
        logic       hit_upd;  // lookup/probe result; touch on lookup only
        logic       put_upd;  // update in place
        logic       evict;    // drop LRU entry
        logic       insert;   // insert new entry
        logic       inval;    // drop lowest matching entry
        logic       clear;
    } lrc_cmd_t;

    typedef struct packed {
        logic [2:0] mode;
        logic       match;
        logic       need_evict;
        logic       kill_any;
    } lrc_sts_t;

    function automatic logic [31:0] entry_cost(input logic present);
        return present ? 32'(BASE_BYTES + DESCRIPTOR_BYTES) : 32'(BASE_BYTES);
    endfunction
endpackage

// ===== hw/rtl/lrc_ctrl.sv =====
// ----------------------------------------------------------------------------
// lrc_ctrl
// Sequencer: accept, match, evict or invalidate loop, update, respond.
// ----------------------------------------------------------------------------
module lrc_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    output logic              m_valid,
    input  logic              m_ready,
    input  lrc_pkg::lrc_sts_t sts,
    output lrc_pkg::lrc_cmd_t cmd
);
    typedef enum logic [4:0] {
        ST_IDLE  = 5'b00001,
        ST_EXEC  = 5'b00010,
        ST_EVICT = 5'b00100,
        ST_INVAL = 5'b01000,
        ST_RESP  = 5'b10000
    } state_t;

    state_t state_reg, state_next;

    assign s_ready = (state_reg == ST_IDLE);
    assign m_valid = (state_reg == ST_RESP);

    always_comb begin
        state_next = state_reg;
        cmd = '0;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    cmd.load = 1'b1;
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC: begin
                state_next = ST_RESP;
                unique case (sts.mode)
                    lrc_pkg::MODE_LOOKUP, lrc_pkg::MODE_PROBE: cmd.hit_upd = 1'b1;
                    lrc_pkg::MODE_PUT: begin
                        if (sts.match) cmd.put_upd = 1'b1;
                        else state_next = ST_EVICT;
                    end
                    lrc_pkg::MODE_INVAL: state_next = ST_INVAL;
                    lrc_pkg::MODE_CLEAR: cmd.clear = 1'b1;
                    default: ;
                endcase
            end
            ST_EVICT: begin
                if (sts.need_evict) begin
                    cmd.evict = 1'b1;
                end else begin
                    cmd.insert = 1'b1;
                    state_next = ST_RESP;
                end
            end
            ST_INVAL: begin
                if (sts.kill_any) begin
                    cmd.inval = 1'b1;
                end else begin
                    state_next = ST_RESP;
                end
            end
            ST_RESP: begin
                if (m_ready) state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) state_reg <= ST_IDLE;
        else state_reg <= state_next;
    end

`ifndef ASSERT_OFF
    a_onehot: assert property (@(posedge aclk) disable iff (!aresetn) $onehot(state_reg))
        else $error("state not one-hot");
    a_ins_resp: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.insert |=> m_valid) else $error("insert not followed by response");
    a_load_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.load |-> !m_valid) else $error("load while responding");
`endif
endmodule

// ===== hw/rtl/lrc_dp.sv =====
// ----------------------------------------------------------------------------
// lrc_dp
// Slot array, parallel key match, age ranks, byte and hit counters.
// ----------------------------------------------------------------------------
module lrc_dp (
    input  logic              aclk,
    input  logic              aresetn,
    input  lrc_pkg::lrc_cmd_t cmd,
    output lrc_pkg::lrc_sts_t sts,
    input  logic              cfg_we,
    input  logic [31:0]       cfg_wdata,
    input  logic [2:0]        s_mode,
    input  logic [63:0]       s_entity_key,
    input  logic [15:0]       s_column_key,
    input  logic [63:0]       s_time_key,
    input  logic              s_payload_present,
    input  logic [63:0]       s_payload_word,
    output logic              m_hit,
    output logic              m_found_present,
    output logic [63:0]       m_found_word,
    output logic [31:0]       m_bytes_used,
    output logic [6:0]        m_entry_count,
    output logic [63:0]       m_hit_total,
    output logic [63:0]       m_miss_total
);
    localparam int N = lrc_pkg::ENTRIES;
    localparam int IW = lrc_pkg::IDX_W;
    localparam int CW = lrc_pkg::CNT_W;

    logic [N-1:0]  valid_reg;
    logic [63:0]   ent_reg [N];
    logic [15:0]   col_reg [N];
    logic [63:0]   tim_reg [N];
    logic          hp_reg  [N];
    logic [lrc_pkg::PAYLOAD_BITS-1:0] pl_reg [N];
    logic [IW-1:0] rank_reg [N];

    logic [2:0]  mode_reg;
    logic [63:0] e_reg, t_reg, w_reg;
    logic [15:0] c_reg;
    logic        p_reg;
    logic [31:0] max_reg, bytes_reg;
    logic [CW-1:0] count_reg;
    logic [63:0] hits_reg, miss_reg;
    logic        hit_reg, fp_reg;
    logic [63:0] fw_reg;

    logic [N-1:0] match_reg, imatch;
    logic [N-1:0] lru_vec, free_vec;
    logic [IW-1:0] ms, lru_s, free_s;
    logic [31:0] cost;
    logic [32:0] need_sum;

    assign cost = lrc_pkg::entry_cost(p_reg);

    always_comb begin
        ms = '0; lru_s = '0; free_s = '0;
        for (int i = N - 1; i >= 0; i--) begin
            imatch[i]  = valid_reg[i] && ent_reg[i] == s_entity_key
                         && col_reg[i] == s_column_key && tim_reg[i] == s_time_key;
            lru_vec[i] = valid_reg[i] && rank_reg[i] == IW'(count_reg - CW'(1));
            free_vec[i] = !valid_reg[i];
            if (match_reg[i]) ms = IW'(i);
            if (lru_vec[i]) lru_s = IW'(i);
            if (free_vec[i]) free_s = IW'(i);
        end
    end

    // Invalidate drops the lowest matching slot, one per cycle.
    logic [N-1:0]  kill;
    logic [IW-1:0] kill_s;
    always_comb begin
        kill_s = '0;
        for (int i = N - 1; i >= 0; i--) begin
            kill[i] = valid_reg[i] && ent_reg[i] == e_reg
                      && (c_reg == lrc_pkg::ALL_COLUMNS || col_reg[i] == c_reg);
            if (kill[i]) kill_s = IW'(i);
        end
    end

    assign need_sum = {1'b0, bytes_reg} + {1'b0, cost};
    assign sts.mode = mode_reg;
    assign sts.match = |match_reg;
    assign sts.need_evict = (count_reg != '0)
        && (need_sum > {1'b0, max_reg} || count_reg >= CW'(N));
    assign sts.kill_any = |kill;

    function automatic logic [31:0] sub_sat(input logic [31:0] a, input logic [31:0] b);
        return a > b ? a - b : 32'd0;
    endfunction

    function automatic logic [31:0] add_sat(input logic [31:0] a, input logic [31:0] b);
        logic [32:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[32] ? 32'hFFFF_FFFF : s[31:0];
    endfunction

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0; bytes_reg <= '0; count_reg <= '0;
            hits_reg <= '0; miss_reg <= '0; max_reg <= lrc_pkg::MAX_BYTES_RESET;
        end else begin
            if (cfg_we) max_reg <= cfg_wdata;
            if (cmd.load) begin
                mode_reg <= s_mode; e_reg <= s_entity_key; c_reg <= s_column_key;
                t_reg <= s_time_key; p_reg <= s_payload_present;
                w_reg <= s_payload_present ? s_payload_word : 64'd0;
                match_reg <= imatch;
                hit_reg <= 1'b0; fp_reg <= 1'b0; fw_reg <= '0;
            end
            if (cmd.hit_upd && sts.match) begin
                hit_reg <= 1'b1; fp_reg <= hp_reg[ms];
                fw_reg <= hp_reg[ms] ? 64'(pl_reg[ms]) : 64'd0;
            end
            if (cmd.hit_upd && mode_reg == lrc_pkg::MODE_LOOKUP) begin
                if (sts.match) hits_reg <= hits_reg + 64'd1;
                else miss_reg <= miss_reg + 64'd1;
            end
            if ((cmd.hit_upd && mode_reg == lrc_pkg::MODE_LOOKUP && sts.match) || cmd.put_upd) begin
                for (int i = 0; i < N; i++)
                    if (valid_reg[i] && rank_reg[i] < rank_reg[ms]) rank_reg[i] <= rank_reg[i] + IW'(1);
                rank_reg[ms] <= '0;
            end
            if (cmd.put_upd) begin
                bytes_reg <= add_sat(sub_sat(bytes_reg, lrc_pkg::entry_cost(hp_reg[ms])), cost);
                hp_reg[ms] <= p_reg;
                pl_reg[ms] <= w_reg[lrc_pkg::PAYLOAD_BITS-1:0];
            end
            if (cmd.evict) begin
                valid_reg[lru_s] <= 1'b0;
                count_reg <= count_reg - CW'(1);
                bytes_reg <= sub_sat(bytes_reg, lrc_pkg::entry_cost(hp_reg[lru_s]));
            end
            if (cmd.insert) begin
                for (int i = 0; i < N; i++)
                    if (valid_reg[i]) rank_reg[i] <= rank_reg[i] + IW'(1);
                valid_reg[free_s] <= 1'b1;
                ent_reg[free_s] <= e_reg; col_reg[free_s] <= c_reg;
                tim_reg[free_s] <= t_reg; hp_reg[free_s] <= p_reg;
                pl_reg[free_s] <= w_reg[lrc_pkg::PAYLOAD_BITS-1:0];
                rank_reg[free_s] <= '0;
                count_reg <= count_reg + CW'(1);
                bytes_reg <= add_sat(bytes_reg, cost);
            end
            if (cmd.inval) begin
                for (int i = 0; i < N; i++)
                    if (valid_reg[i] && rank_reg[i] > rank_reg[kill_s])
                        rank_reg[i] <= rank_reg[i] - IW'(1);
                valid_reg[kill_s] <= 1'b0;
                count_reg <= count_reg - CW'(1);
                bytes_reg <= sub_sat(bytes_reg, lrc_pkg::entry_cost(hp_reg[kill_s]));
            end
            if (cmd.clear) begin
                valid_reg <= '0; count_reg <= '0; bytes_reg <= '0;
            end
        end
    end

    assign m_hit = hit_reg;
    assign m_found_present = fp_reg;
    assign m_found_word = fw_reg;
    assign m_bytes_used = bytes_reg;
    assign m_entry_count = 7'(count_reg);
    assign m_hit_total = hits_reg;
    assign m_miss_total = miss_reg;

`ifndef ASSERT_OFF
    a_cnt: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg == CW'($countones(valid_reg))) else $error("count mismatch");
    a_match: assert property (@(posedge aclk) disable iff (!aresetn)
        $onehot0(match_reg & valid_reg)) else $error("duplicate key");
    a_evict: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.evict |-> count_reg != '0) else $error("evict on empty");
`endif
endmodule

// ===== hw/rtl/lru_result_cache_byte_budget.sv =====
// ----------------------------------------------------------------------------
// lru_result_cache_byte_budget
// Fully associative 64-entry LRU result cache with byte budget.
// ----------------------------------------------------------------------------
// channel   dir  handshake          words
// s_*       in   s_valid/s_ready    one request word
// m_*       out  m_valid/m_ready    one response word
// cfg       in   cfg_we             max_bytes, no wait
// Lookup, probe, clear, unknown mode and in-place put: idle, execute, respond.
// New-key put: idle, execute, evict state (LRU evictions, then insert), respond.
// Invalidate: idle, execute, invalidate state (removes entries one at a time), respond.
// Key match is fully parallel; eviction and invalidate loop over entries one at a time.
// aresetn synchronous: cache empty, counters zero, max_bytes 65536.
// m stall holds the response and blocks the next request.
module lru_result_cache_byte_budget (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic [31:0] cfg_wdata,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [2:0]  s_mode,
    input  logic [63:0] s_entity_key,
    input  logic [15:0] s_column_key,
    input  logic [63:0] s_time_key,
    input  logic        s_payload_present,
    input  logic [63:0] s_payload_word,
    output logic        m_valid,
    input  logic        m_ready,
    output logic        m_hit,
    output logic        m_found_present,
    output logic [63:0] m_found_word,
    output logic [31:0] m_bytes_used,
    output logic [6:0]  m_entry_count,
    output logic [63:0] m_hit_total,
    output logic [63:0] m_miss_total
);
    lrc_pkg::lrc_cmd_t cmd;
    lrc_pkg::lrc_sts_t sts;

    lrc_ctrl u_ctrl (.aclk, .aresetn, .s_valid, .s_ready, .m_valid, .m_ready, .sts, .cmd);

    lrc_dp u_dp (.aclk, .aresetn, .cmd, .sts, .cfg_we, .cfg_wdata, .s_mode, .s_entity_key,
                 .s_column_key, .s_time_key, .s_payload_present, .s_payload_word, .m_hit,
                 .m_found_present, .m_found_word, .m_bytes_used, .m_entry_count,
                 .m_hit_total, .m_miss_total);
endmodule
